// ===== rtl/core/sfta_pkg.sv =====
`timescale 1ns / 1ps

package sfta_pkg;

    // One vertex as it travels through the block.
    typedef struct packed {
        logic [14:0]        position_index;
        logic [14:0]        normal_index;
        logic signed [15:0] tex_s;
        logic signed [15:0] tex_t;
    } vtx_t;

    // One assembled triangle, corners in emission order.
    typedef struct packed {
        vtx_t [2:0] verts;
        logic       from_fan;
    } tri_t;

    // Queue status seen by the front end.
    typedef struct packed {
        logic full;
        logic valid;
    } qstat_t;

    // Which of the four vertex words comes next.
    localparam logic [1:0] FieldPos  = 2'd0;
    localparam logic [1:0] FieldNorm = 2'd1;
    localparam logic [1:0] FieldS    = 2'd2;
    localparam logic [1:0] FieldT    = 2'd3;

    // Corner numbers within a triangle.
    localparam logic [1:0] CornerFirst  = 2'd0;
    localparam logic [1:0] CornerSecond = 2'd1;
    localparam logic [1:0] CornerLast   = 2'd2;

    // Window fill levels.
    localparam logic [1:0] WinEmpty = 2'd0;
    localparam logic [1:0] WinOne   = 2'd1;
    localparam logic [1:0] WinTwo   = 2'd2;
    localparam logic [1:0] WinFull  = 2'd3;

    // Smallest vertex count that a primitive reads.
    localparam logic [15:0] MinVertices = 16'd3;

endpackage

// ===== rtl/core/sfta_front.sv =====
`timescale 1ns / 1ps

module sfta_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_command_word,
    input  sfta_pkg::qstat_t     q_stat,
    output logic                 push,
    output sfta_pkg::tri_t       push_data
);

    logic               in_prim_reg, in_prim_next;
    logic               fan_reg, fan_next;
    logic [15:0]        remain_reg, remain_next;
    logic [1:0]         field_reg, field_next;
    logic [1:0]         count_reg, count_next;
    logic               rev_reg, rev_next;
    logic [14:0]        pos_reg;
    logic [14:0]        norm_reg;
    logic signed [15:0] s_reg;
    sfta_pkg::vtx_t     win_reg [3];

    logic               accept;
    logic [15:0]        word;
    logic [15:0]        mag;
    logic               vtx_done;
    sfta_pkg::vtx_t     new_vtx;

    // A word is taken whenever the queue has room for a triangle.
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign word    = s_command_word;
    assign mag     = word[15] ? (~word + 16'd1) : word;

    assign vtx_done = accept && in_prim_reg && (field_reg == sfta_pkg::FieldT);

    // The vertex completed by the current word.
    assign new_vtx.position_index = pos_reg;
    assign new_vtx.normal_index   = norm_reg;
    assign new_vtx.tex_s          = s_reg;
    assign new_vtx.tex_t          = s_command_word;

    // Header decoding and vertex counting.
    always_comb begin
        in_prim_next = in_prim_reg;
        fan_next     = fan_reg;
        remain_next  = remain_reg;
        field_next   = field_reg;
        count_next   = count_reg;
        rev_next     = rev_reg;
        if (accept) begin
            if (!in_prim_reg) begin
                if (word != 16'd0) begin
                    in_prim_next = 1'b1;
                    fan_next     = word[15];
                    remain_next  = (mag < sfta_pkg::MinVertices) ? sfta_pkg::MinVertices : mag;
                    field_next   = sfta_pkg::FieldPos;
                    count_next   = sfta_pkg::WinEmpty;
                    rev_next     = 1'b0;
                end
            end else if (field_reg != sfta_pkg::FieldT) begin
                field_next = field_reg + 2'd1;
            end else begin
                field_next = sfta_pkg::FieldPos;
                if (count_reg != sfta_pkg::WinFull) begin
                    count_next = count_reg + 2'd1;
                end else if (!fan_reg) begin
                    rev_next = !rev_reg;
                end
                if (remain_reg <= 16'd1) begin
                    remain_next  = 16'd0;
                    in_prim_next = 1'b0;
                end else begin
                    remain_next = remain_reg - 16'd1;
                end
            end
        end
    end

    // Triangle formed by the completed vertex, if any.
    always_comb begin
        push_data.from_fan = fan_reg;
        push_data.verts[0] = win_reg[0];
        push_data.verts[1] = win_reg[1];
        push_data.verts[2] = new_vtx;
        push = 1'b0;
        if (vtx_done) begin
            if (count_reg == sfta_pkg::WinTwo) begin
                push = 1'b1;
            end else if (count_reg == sfta_pkg::WinFull) begin
                push = 1'b1;
                if (fan_reg) begin
                    push_data.verts[1] = win_reg[2];
                end else if (!rev_reg) begin
                    push_data.verts[0] = new_vtx;
                    push_data.verts[1] = win_reg[2];
                    push_data.verts[2] = win_reg[1];
                end else begin
                    push_data.verts[0] = win_reg[1];
                    push_data.verts[1] = win_reg[2];
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_prim_reg <= 1'b0;
            fan_reg     <= 1'b0;
            remain_reg  <= 16'd0;
            field_reg   <= sfta_pkg::FieldPos;
            count_reg   <= sfta_pkg::WinEmpty;
            rev_reg     <= 1'b0;
        end else begin
            in_prim_reg <= in_prim_next;
            fan_reg     <= fan_next;
            remain_reg  <= remain_next;
            field_reg   <= field_next;
            count_reg   <= count_next;
            rev_reg     <= rev_next;
        end
    end

    // Partial vertex words and the vertex window.
    always_ff @(posedge aclk) begin
        if (accept && in_prim_reg) begin
            case (field_reg)
                sfta_pkg::FieldPos:  pos_reg  <= word[14:0];
                sfta_pkg::FieldNorm: norm_reg <= word[14:0];
                sfta_pkg::FieldS:    s_reg    <= s_command_word;
                default: begin
                    case (count_reg)
                        sfta_pkg::WinEmpty: win_reg[0] <= new_vtx;
                        sfta_pkg::WinOne:   win_reg[1] <= new_vtx;
                        sfta_pkg::WinTwo:   win_reg[2] <= new_vtx;
                        default: begin
                            if (!fan_reg) begin
                                win_reg[0] <= win_reg[1];
                            end
                            win_reg[1] <= win_reg[2];
                            win_reg[2] <= new_vtx;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/sfta_queue.sv =====
`timescale 1ns / 1ps

module sfta_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sfta_pkg::tri_t   push_data,
    input  logic             pop,
    output sfta_pkg::tri_t   pop_data,
    output sfta_pkg::qstat_t stat
);

    sfta_pkg::tri_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;

    assign stat.full  = (fill_reg == 2'd2);
    assign stat.valid = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Triangle storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/sfta_back.sv =====
`timescale 1ns / 1ps

module sfta_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  sfta_pkg::tri_t     q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_position_index,
    output logic [14:0]        m_normal_index,
    output logic signed [15:0] m_tex_s,
    output logic signed [15:0] m_tex_t,
    output logic [1:0]         m_corner,
    output logic               m_from_fan,
    output logic               m_last_corner
);

    sfta_pkg::tri_t tri_reg;
    logic [1:0]     corner_reg, corner_next;
    logic           busy_reg, busy_next;
    logic           out_done;
    sfta_pkg::vtx_t cur;

    // A new triangle is loaded when idle or as the last corner leaves.
    assign out_done = busy_reg && m_ready && (corner_reg == sfta_pkg::CornerLast);
    assign pop      = q_valid && (!busy_reg || out_done);

    always_comb begin
        busy_next   = busy_reg;
        corner_next = corner_reg;
        if (pop) begin
            busy_next   = 1'b1;
            corner_next = sfta_pkg::CornerFirst;
        end else if (out_done) begin
            busy_next = 1'b0;
        end else if (busy_reg && m_ready) begin
            corner_next = corner_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            corner_reg <= sfta_pkg::CornerFirst;
        end else begin
            busy_reg   <= busy_next;
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            tri_reg <= q_data;
        end
    end

    // Corner selection from the held triangle.
    always_comb begin
        case (corner_reg)
            sfta_pkg::CornerFirst:  cur = tri_reg.verts[0];
            sfta_pkg::CornerSecond: cur = tri_reg.verts[1];
            default:                cur = tri_reg.verts[2];
        endcase
    end

    assign m_valid          = busy_reg;
    assign m_position_index = cur.position_index;
    assign m_normal_index   = cur.normal_index;
    assign m_tex_s          = cur.tex_s;
    assign m_tex_t          = cur.tex_t;
    assign m_corner         = corner_reg;
    assign m_from_fan       = tri_reg.from_fan;
    assign m_last_corner    = (corner_reg == sfta_pkg::CornerLast);

endmodule

// ===== rtl/core/strip_fan_triangle_assembly.sv =====
// A completed triangle is queued, then registered in the back end, before its first corner leaves.
// Throughput: one command word per cycle while the queue is not full; each triangle leaves as three corners,
// one per cycle while m_ready is high, and a two-entry triangle queue absorbs output stalls.
// Reset: synchronous, active-low aresetn clears the header, counting, queue and corner control
// state; vertex and triangle payload registers are not reset.
`timescale 1ns / 1ps

module strip_fan_triangle_assembly (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_command_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_position_index,
    output logic [14:0]        m_normal_index,
    output logic signed [15:0] m_tex_s,
    output logic signed [15:0] m_tex_t,
    output logic [1:0]         m_corner,
    output logic               m_from_fan,
    output logic               m_last_corner
);

    sfta_pkg::qstat_t q_stat;
    sfta_pkg::tri_t   push_data;
    sfta_pkg::tri_t   pop_data;
    logic             push;
    logic             pop;

    // Word parsing and triangle formation.
    sfta_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command_word (s_command_word),
        .q_stat         (q_stat),
        .push           (push),
        .push_data      (push_data)
    );

    // Triangle queue between the two halves.
    sfta_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // Corner emission.
    sfta_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_stat.valid),
        .q_data           (pop_data),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position_index (m_position_index),
        .m_normal_index   (m_normal_index),
        .m_tex_s          (m_tex_s),
        .m_tex_t          (m_tex_t),
        .m_corner         (m_corner),
        .m_from_fan       (m_from_fan),
        .m_last_corner    (m_last_corner)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Cycles to let pass once the last expected corner has arrived.
    localparam int DRAIN_CYCLES = 10;
    // Hard stop for the whole run, far beyond the slowest correct run.
    localparam int RUN_LIMIT_NS = 5_000_000;

    // One triangle corner as it leaves the block.
    typedef struct packed {
        logic [14:0]        position_index;
        logic [14:0]        normal_index;
        logic signed [15:0] tex_s;
        logic signed [15:0] tex_t;
        logic [1:0]         corner;
        logic               from_fan;
        logic               last_corner;
    } corner_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_command_word;
    logic               m_valid;
    logic               m_ready;
    logic [14:0]        m_position_index;
    logic [14:0]        m_normal_index;
    logic signed [15:0] m_tex_s;
    logic signed [15:0] m_tex_t;
    logic [1:0]         m_corner;
    logic               m_from_fan;
    logic               m_last_corner;

    // Corners still owed by the block, oldest first.
    corner_t corners_due[$];

    int errors        = 0;
    int words_sent    = 0;
    int corners_seen  = 0;
    int strip_tris    = 0;
    int fan_tris      = 0;
    bit sender_idles  = 1'b1;
    bit receiver_idles = 1'b1;

    // Assembler state mirrored in the testbench.
    logic              asm_active;
    logic              asm_fan;
    logic [15:0]       asm_left;
    logic [1:0]        asm_field;
    logic [1:0]        asm_fill;
    logic              asm_flip;
    logic [15:0]       asm_words[3];
    sfta_pkg::vtx_t    asm_window[3];

    strip_fan_triangle_assembly u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command_word  (s_command_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position_index(m_position_index),
        .m_normal_index  (m_normal_index),
        .m_tex_s         (m_tex_s),
        .m_tex_t         (m_tex_t),
        .m_corner        (m_corner),
        .m_from_fan      (m_from_fan),
        .m_last_corner   (m_last_corner)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: run timed out with %0d corners outstanding", $time, corners_due.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // Idle lengths: mostly the given shortest, some short, a few long.
    function automatic int pick_gap(input int shortest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return shortest;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic string show_corner(input corner_t c);
        return $sformatf("pos %0d nrm %0d s %0d t %0d corner %0d fan %0d last %0d",
                         c.position_index, c.normal_index, c.tex_s, c.tex_t,
                         c.corner, c.from_fan, c.last_corner);
    endfunction

    // Queue the three corners of one triangle in emission order.
    function automatic void queue_triangle(input sfta_pkg::vtx_t a, input sfta_pkg::vtx_t b,
                                           input sfta_pkg::vtx_t c);
        sfta_pkg::vtx_t trio[3];
        corner_t        item;
        trio = '{a, b, c};
        for (int k = 0; k < 3; k++) begin
            item.position_index = trio[k].position_index;
            item.normal_index   = trio[k].normal_index;
            item.tex_s          = trio[k].tex_s;
            item.tex_t          = trio[k].tex_t;
            item.corner         = (k == 0) ? sfta_pkg::CornerFirst :
                                  (k == 1) ? sfta_pkg::CornerSecond : sfta_pkg::CornerLast;
            item.from_fan       = asm_fan;
            item.last_corner    = (k == 2);
            corners_due         = {corners_due, item};
        end
    endfunction

    // Advance the mirrored assembler by one accepted command word.
    function automatic void assemble_word(input logic [15:0] w);
        logic [16:0]    count;
        sfta_pkg::vtx_t vert;
        if (!asm_active) begin
            // Header: zero ends the mesh, the sign picks strip or fan.
            if (w != 16'd0) begin
                asm_fan    = w[15];
                count      = w[15] ? (17'h10000 - {1'b0, w}) : {1'b0, w};
                asm_left   = (count < sfta_pkg::MinVertices) ? sfta_pkg::MinVertices
                                                             : count[15:0];
                asm_active = 1'b1;
                asm_field  = sfta_pkg::FieldPos;
                asm_fill   = sfta_pkg::WinEmpty;
                asm_flip   = 1'b0;
            end
        end else if (asm_field != sfta_pkg::FieldT) begin
            asm_words[asm_field] = w;
            asm_field++;
        end else begin
            // The fourth word completes a vertex; index words keep 15 bits.
            vert.position_index = asm_words[sfta_pkg::FieldPos][14:0];
            vert.normal_index   = asm_words[sfta_pkg::FieldNorm][14:0];
            vert.tex_s          = asm_words[sfta_pkg::FieldS];
            vert.tex_t          = w;
            asm_field           = sfta_pkg::FieldPos;
            if (asm_fill != sfta_pkg::WinFull) begin
                asm_window[asm_fill] = vert;
                asm_fill++;
                if (asm_fill == sfta_pkg::WinFull) begin
                    queue_triangle(asm_window[0], asm_window[1], asm_window[2]);
                end
            end else if (asm_fan) begin
                // A fan keeps its first vertex.
                asm_window[1] = asm_window[2];
                asm_window[2] = vert;
                queue_triangle(asm_window[0], asm_window[1], asm_window[2]);
            end else begin
                // A strip slides its window and alternates the winding.
                asm_window[0] = asm_window[1];
                asm_window[1] = asm_window[2];
                asm_window[2] = vert;
                if (asm_flip) begin
                    queue_triangle(asm_window[0], asm_window[1], asm_window[2]);
                end else begin
                    queue_triangle(asm_window[2], asm_window[1], asm_window[0]);
                end
                asm_flip = ~asm_flip;
            end
            asm_left--;
            if (asm_left == 16'd0) begin
                asm_active = 1'b0;
            end
        end
    endfunction

    // Offer one command word and wait for its transfer.
    task automatic send_word(input logic signed [15:0] w);
        int gap;
        gap = sender_idles ? pick_gap(0) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command_word <= w;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        assemble_word(w);
        words_sent++;
    endtask

    task automatic send_vertex(input logic [15:0] pos, input logic [15:0] nrm,
                               input logic [15:0] s, input logic [15:0] t);
        send_word(pos);
        send_word(nrm);
        send_word(s);
        send_word(t);
    endtask

    // Random vertex word, leaning now and then on the extremes.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random header: mostly ordinary counts, some short ones and terminators.
    function automatic logic signed [15:0] rand_header();
        int r;
        int count;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            count = 0;
        end else if (r < 25) begin
            count = $urandom_range(1, 2);
        end else if (r < 88) begin
            count = $urandom_range(3, 8);
        end else begin
            count = $urandom_range(9, 20);
        end
        return 16'($urandom_range(0, 1) ? -count : count);
    endfunction

    // One whole primitive: header and as many random vertices as it reads.
    task automatic send_mesh(input logic signed [15:0] header);
        int count;
        send_word(header);
        count = (header < 0) ? -int'(header) : int'(header);
        if (count != 0) begin
            if (count < 3) begin
                count = 3;
            end
            repeat (count) send_vertex(rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    // Stop offering words until every owed corner has come out.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (corners_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Terminators on their own produce nothing.
    task automatic test_terminator();
        send_word(16'sd0);
        send_word(16'sd0);
    endtask

    // A count of one still reads three vertices; extreme and negative index words.
    task automatic test_short_strip();
        send_word(16'sd1);
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_vertex(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_vertex(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_random_meshes(input int budget);
        int first;
        first = words_sent;
        while (words_sent - first < budget) send_mesh(rand_header());
    endtask

    // The sender waits for the output side to empty between primitives.
    task automatic test_pause_until_drained();
        send_mesh(16'sd5);
        hold_until_drained();
        send_mesh(-16'sd4);
        hold_until_drained();
    endtask

    // The most negative header opens a very long fan; only its start is sent.
    task automatic test_most_negative_header();
        send_word(16'sh8000);
        send_vertex(16'h8001, 16'hC000, 16'h0001, 16'hFFFE);
        repeat (4) send_vertex(rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    // Result side: random back-pressure when enabled.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (receiver_idles && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap(1)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Compare each corner transfer with the oldest owed corner.
    always @(posedge aclk) begin : check_corners
        corner_t got;
        corner_t want;
        if (aresetn && m_valid && m_ready) begin
            got.position_index = m_position_index;
            got.normal_index   = m_normal_index;
            got.tex_s          = m_tex_s;
            got.tex_t          = m_tex_t;
            got.corner         = m_corner;
            got.from_fan       = m_from_fan;
            got.last_corner    = m_last_corner;
            corners_seen++;
            if (corners_due.size() == 0) begin
                $display("%0t: corner with nothing expected, actual %s", $time, show_corner(got));
                errors++;
            end else begin
                want = corners_due.pop_front();
                if (got !== want) begin
                    $display("%0t: corner mismatch, expected %s, actual %s",
                             $time, show_corner(want), show_corner(got));
                    errors++;
                end else if (got.last_corner) begin
                    if (got.from_fan) begin
                        fan_tris++;
                    end else begin
                        strip_tris++;
                    end
                end
            end
        end
    end

    // Test sequence.
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_command_word = '0;
        asm_active     = 1'b0;
        asm_fan        = 1'b0;
        asm_left       = '0;
        asm_field      = sfta_pkg::FieldPos;
        asm_fill       = sfta_pkg::WinEmpty;
        asm_flip       = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_terminator();
        test_short_strip();

        // A stretch with no idling on either side.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_meshes(40);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        test_random_meshes(110);
        test_pause_until_drained();
        test_random_meshes(110);
        test_most_negative_header();

        s_valid <= 1'b0;
        while (corners_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d command words of strips, fans, short counts and terminators;",
                 words_sent);
        $display("checked %0d corners: %0d strip and %0d fan triangles.",
                 corners_seen, strip_tris, fan_tris);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
